// File: hdl/lkh_pkg.sv
// Shared types, constants and mixing functions of the lookup3 byte hash.
package lkh_pkg;

  // Initial value of the hash words before length and seed
  localparam logic [31:0] InitConst  = 32'hdeadbeef;
  // Bytes held in one full block
  localparam logic [3:0]  BlockBytes = 4'd12;

  // Register index codes on the configuration port
  localparam logic RegPrimary   = 1'b0;
  localparam logic RegSecondary = 1'b1;

  // Lane selects inside a block: word a, word b (word c is the default)
  localparam logic [1:0] LaneA = 2'd0;
  localparam logic [1:0] LaneB = 2'd1;

  // One classified item, passed from front to back
  typedef struct packed {
    logic        first;       // opens a message: set up the words
    logic        mix_before;  // full block pending: mix before adding
    logic        present;     // carries a byte
    logic [3:0]  lane;        // byte position inside the block, 0..11 when present is set
    logic [7:0]  byte_val;
    logic        last;        // closes the message
    logic        fin;         // at least one byte seen: final mix needed
    logic        mismatch;    // byte count differs from declared length
    logic [31:0] length;      // declared length, used when first is set
  } lkh_op_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } lkh_words_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

  // First three rows of the block mix
  function automatic lkh_words_t mix_lo(input lkh_words_t w);
    logic [31:0] a, b, c;
    a = w.a; b = w.b; c = w.c;
    a = a - c; a = a ^ rotl(c, 4);  c = c + b;
    b = b - a; b = b ^ rotl(a, 6);  a = a + c;
    c = c - b; c = c ^ rotl(b, 8);  b = b + a;
    mix_lo = '{a: a, b: b, c: c};
  endfunction

  // Last three rows of the block mix
  function automatic lkh_words_t mix_hi(input lkh_words_t w);
    logic [31:0] a, b, c;
    a = w.a; b = w.b; c = w.c;
    a = a - c; a = a ^ rotl(c, 16); c = c + b;
    b = b - a; b = b ^ rotl(a, 19); a = a + c;
    c = c - b; c = c ^ rotl(b, 4);  b = b + a;
    mix_hi = '{a: a, b: b, c: c};
  endfunction

  // First four rows of the final mix
  function automatic lkh_words_t fin_lo(input lkh_words_t w);
    logic [31:0] a, b, c;
    a = w.a; b = w.b; c = w.c;
    c = c ^ b; c = c - rotl(b, 14);
    a = a ^ c; a = a - rotl(c, 11);
    b = b ^ a; b = b - rotl(a, 25);
    c = c ^ b; c = c - rotl(b, 16);
    fin_lo = '{a: a, b: b, c: c};
  endfunction

  // Last three rows of the final mix
  function automatic lkh_words_t fin_hi(input lkh_words_t w);
    logic [31:0] a, b, c;
    a = w.a; b = w.b; c = w.c;
    a = a ^ c; a = a - rotl(c, 4);
    b = b ^ a; b = b - rotl(a, 14);
    c = c ^ b; c = c - rotl(b, 24);
    fin_hi = '{a: a, b: b, c: c};
  endfunction

endpackage

// File: hdl/lkh_front.sv
// Front end: accepts input beats, tracks message framing and classifies each item.
module lkh_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        byte_value_i,
  input  logic              byte_present_i,
  input  logic              is_last_i,
  input  logic [31:0]       message_length_i,
  input  logic              q_ready_i,
  output logic              q_push_o,
  output lkh_pkg::lkh_op_t  q_op_o
);
  import lkh_pkg::*;

  logic        in_msg_q, in_msg_d;
  logic [3:0]  pos_q, pos_d;
  logic [31:0] cnt_q, cnt_d;
  logic [31:0] decl_q, decl_d;

  logic        first;
  logic [3:0]  pos_cur, lane, pos_nxt;
  logic [31:0] cnt_cur, cnt_nxt, decl_cur;
  logic        mix_before;
  logic        accept;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i & q_ready_i;
  assign q_push_o   = accept;

  // Classify the current beat against the running message state
  always_comb begin
    first      = ~in_msg_q;
    pos_cur    = first ? 4'd0 : pos_q;
    cnt_cur    = first ? 32'd0 : cnt_q;
    decl_cur   = first ? message_length_i : decl_q;
    mix_before = byte_present_i & (pos_cur == BlockBytes);
    lane       = mix_before ? 4'd0 : pos_cur;
    pos_nxt    = byte_present_i ? 4'(lane + 4'd1) : pos_cur;
    cnt_nxt    = 32'(cnt_cur + {31'd0, byte_present_i});

    q_op_o.first      = first;
    q_op_o.mix_before = mix_before;
    q_op_o.present    = byte_present_i;
    q_op_o.lane       = lane;
    q_op_o.byte_val   = byte_value_i;
    q_op_o.last       = is_last_i;
    q_op_o.fin        = (pos_nxt != 4'd0);
    q_op_o.mismatch   = (cnt_nxt != decl_cur);
    q_op_o.length     = message_length_i;
  end

  // Advance framing state on each accepted beat
  always_comb begin
    in_msg_d = in_msg_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    decl_d   = decl_q;
    if (accept) begin
      in_msg_d = ~is_last_i;
      pos_d    = is_last_i ? 4'd0 : pos_nxt;
      cnt_d    = is_last_i ? 32'd0 : cnt_nxt;
      decl_d   = decl_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_msg_q <= 1'b0;
      pos_q    <= 4'd0;
      cnt_q    <= 32'd0;
      decl_q   <= 32'd0;
    end else begin
      in_msg_q <= in_msg_d;
      pos_q    <= pos_d;
      cnt_q    <= cnt_d;
      decl_q   <= decl_d;
    end
  end

endmodule

// File: hdl/lkh_queue.sv
// Short FIFO of classified items between front end and back end.
module lkh_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lkh_pkg::lkh_op_t  op_i,
  output logic              ready_o,
  input  logic              pop_i,
  output logic              valid_o,
  output lkh_pkg::lkh_op_t  op_o
);
  import lkh_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  lkh_op_t             mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign ready_o = (cnt_q != CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign op_o    = mem_q[rd_ptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  // Advance pointers with wrap at the depth and track the fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end else if (!do_push && do_pop) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the entry; payload needs no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

// File: hdl/lkh_back.sv
// Back end: holds the hash words, runs byte adds, block mix and final mix, drives results.
module lkh_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              op_valid_i,
  input  lkh_pkg::lkh_op_t  op_i,
  output logic              pop_o,
  input  logic [31:0]       primary_seed_i,
  input  logic [31:0]       secondary_seed_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [63:0]       hash_value_o,
  output logic              length_mismatch_o
);
  import lkh_pkg::*;

  localparam logic [1:0] StRun  = 2'd0;
  localparam logic [1:0] StMix2 = 2'd1;
  localparam logic [1:0] StFin1 = 2'd2;
  localparam logic [1:0] StFin2 = 2'd3;

  logic [1:0]  state_q, state_d;
  lkh_words_t  words_q, words_d;
  logic        mism_q, mism_d;
  logic [63:0] res_q, res_d;
  logic        res_mism_q, res_mism_d;
  logic        out_valid_q, out_valid_d;

  lkh_words_t  base, applied, fin_out;
  logic [31:0] init, add;
  logic        out_free, load;

  assign out_free = ~out_valid_q | out_ready_i;
  assign fin_out  = fin_hi(words_q);

  // Finish a pending block mix, set up words on a first item, then add the byte into its lane
  always_comb begin
    base    = (state_q == StMix2) ? mix_hi(words_q) : words_q;
    init    = InitConst + op_i.length + primary_seed_i;
    applied = base;
    if (op_i.first) begin
      applied.a = init;
      applied.b = init;
      applied.c = init + secondary_seed_i;
    end
    add = {24'd0, op_i.byte_val} << {op_i.lane[1:0], 3'b000};
    if (op_i.present) begin
      case (op_i.lane[3:2])
        LaneA:   applied.a = applied.a + add;
        LaneB:   applied.b = applied.b + add;
        default: applied.c = applied.c + add;
      endcase
    end
  end

  // Sequence one item: optional block mix, add, optional final mix
  always_comb begin
    state_d    = state_q;
    words_d    = words_q;
    mism_d     = mism_q;
    res_d      = res_q;
    res_mism_d = res_mism_q;
    pop_o      = 1'b0;
    load       = 1'b0;
    case (state_q)
      StRun, StMix2: begin
        if (op_valid_i) begin
          if ((state_q == StRun) && op_i.mix_before) begin
            words_d = mix_lo(words_q);
            state_d = StMix2;
          end else if (op_i.last && !op_i.fin) begin
            // empty message: seeded words go out unmixed
            if (out_free) begin
              pop_o      = 1'b1;
              load       = 1'b1;
              words_d    = applied;
              res_d      = {applied.b, applied.c};
              res_mism_d = op_i.mismatch;
              state_d    = StRun;
            end
          end else begin
            pop_o   = 1'b1;
            words_d = applied;
            mism_d  = op_i.mismatch;
            state_d = op_i.last ? StFin1 : StRun;
          end
        end
      end
      StFin1: begin
        words_d = fin_lo(words_q);
        state_d = StFin2;
      end
      StFin2: begin
        // hold until the output slot frees
        if (out_free) begin
          load       = 1'b1;
          words_d    = fin_out;
          res_d      = {fin_out.b, fin_out.c};
          res_mism_d = mism_q;
          state_d    = StRun;
        end
      end
      default: state_d = StRun;
    endcase
    out_valid_d = (out_valid_q & ~out_ready_i) | load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StRun;
      out_valid_q <= 1'b0;
      words_q     <= '0;
      mism_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      words_q     <= words_d;
      mism_q      <= mism_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    res_mism_q <= res_mism_d;
  end

  assign out_valid_o       = out_valid_q;
  assign hash_value_o      = res_q;
  assign length_mismatch_o = res_mism_q;

endmodule

// File: hdl/lookup3_byte_hash64.sv
// Top level of the streaming lookup3 (hashlittle2) byte hash with APB seed registers.
//
//  Channel  | Signals                                              | Direction
//  ---------+------------------------------------------------------+----------
//  input    | in_valid_i/in_ready_o, byte_value_i, byte_present_i, | in
//           | is_last_i, message_length_i                          |
//  result   | out_valid_o/out_ready_i, hash_value_o,               | out
//           | length_mismatch_o                                    |
//  config   | psel, penable, pwrite, paddr, pwdata, prdata, pready | APB
//
// One byte beat is taken per cycle while the queue has room. The back end runs each
// block mix in an extra state, StMix2, ahead of the byte add, and the final mix of a
// message in the states StFin1 and StFin2; the item queue absorbs these so the input
// keeps flowing. Reset clears framing, queue, sequencer and seeds; a result beat
// holds while out_ready_i is low, and the input stalls only when the queue fills.
module lookup3_byte_hash64 #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_value_i,
  input  logic        byte_present_i,
  input  logic        is_last_i,
  input  logic [31:0] message_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] hash_value_o,
  output logic        length_mismatch_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lkh_pkg::*;

  logic [31:0] seed_p_q, seed_s_q;
  logic        cfg_wr;
  logic        q_push, q_ready, q_valid, q_pop;
  lkh_op_t     q_in, q_out;

  // Write seed registers on the APB access phase
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == RegSecondary) ? seed_s_q : seed_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_p_q <= 32'd0;
      seed_s_q <= 32'd0;
    end else if (cfg_wr) begin
      if (paddr[2] == RegPrimary) begin
        seed_p_q <= pwdata;
      end else begin
        seed_s_q <= pwdata;
      end
    end
  end

  lkh_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .byte_value_i     (byte_value_i),
    .byte_present_i   (byte_present_i),
    .is_last_i        (is_last_i),
    .message_length_i (message_length_i),
    .q_ready_i        (q_ready),
    .q_push_o         (q_push),
    .q_op_o           (q_in)
  );

  lkh_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .op_i    (q_in),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .op_o    (q_out)
  );

  lkh_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .op_valid_i        (q_valid),
    .op_i              (q_out),
    .pop_o             (q_pop),
    .primary_seed_i    (seed_p_q),
    .secondary_seed_i  (seed_s_q),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .hash_value_o      (hash_value_o),
    .length_mismatch_o (length_mismatch_o)
  );

endmodule

// File: hdl/lkh_checker.sv
// Port-level checks of the lookup3 byte hash, bound to the top level.
module lkh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] hash_value_o,
  input logic        length_mismatch_o,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // Config port never inserts wait states
  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

  // A stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hash_value_o)
      && $stable(length_mismatch_o))
    else $error("result beat changed under stall");

  // A written seed reads back at the same address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite |=> (paddr[2] != $past(paddr[2])) || (prdata == $past(pwdata)))
    else $error("seed readback mismatch");

  // No result beat in the first cycle out of reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result beat out of reset");

endmodule

bind lookup3_byte_hash64 lkh_checker u_lkh_checker (.*);
